// ===== hw/rtl/weighted_lottery_task_picker_core_assert.svh =====
// assertion macros for the weighted lottery task picker
// expects i_clk and i_rst_n in the scope of every use
`ifndef WEIGHTED_LOTTERY_TASK_PICKER_CORE_ASSERT_SVH
`define WEIGHTED_LOTTERY_TASK_PICKER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define WLTP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define WLTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/wltp_pkg.sv =====
// shared types and constants for the weighted lottery task picker
// no dependencies
package wltp_pkg;

    localparam int SLOT_COUNT = 4;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int COUNT_W    = 3;
    localparam int VOLT_W     = 16;
    localparam int SUM_W      = 20;
    localparam int FRAC_W     = 24;
    localparam int PROD_W     = FRAC_W + 1 + SUM_W;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    typedef logic [SLOT_W-1:0]        t_slot;
    typedef logic signed [VOLT_W-1:0] t_volt;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [COUNT_W-1:0]       t_count;
    typedef logic [SLOT_COUNT-1:0]    t_mask;

    // scores in signed q8.12
    localparam t_sum SCORE_TENTH = t_sum'(410);
    localparam t_sum SCORE_FIFTH = t_sum'(819);
    localparam t_sum SCORE_ONE   = t_sum'(4096);

    localparam logic [31:0] PRNG_RESET = 32'h9876_5432;
    localparam t_count      COUNT_RESET = t_count'(1);
    localparam t_mask       MASK_RESET  = t_mask'(1);

    // register index taken from paddr[2]
    typedef enum logic {
        REG_TASK_COUNT  = 1'b0,
        REG_ACTIVE_MASK = 1'b1
    } t_reg_idx;

endpackage

// ===== hw/rtl/wltp_if.sv =====
// handshake channels for the weighted lottery task picker
// depends on wltp_pkg
interface wltp_in_if;
    logic                 valid;
    logic                 ready;
    wltp_pkg::t_volt      voltage_slot1;
    wltp_pkg::t_volt      voltage_slot3;

    modport source (output valid, output voltage_slot1, output voltage_slot3, input ready);
    modport sink   (input valid, input voltage_slot1, input voltage_slot3, output ready);
endinterface

interface wltp_out_if;
    logic                 valid;
    logic                 ready;
    wltp_pkg::t_slot      chosen_slot;
    wltp_pkg::t_slot      previous_slot;
    logic                 switch_needed;

    modport source (output valid, output chosen_slot, output previous_slot,
                    output switch_needed, input ready);
    modport sink   (input valid, input chosen_slot, input previous_slot,
                    input switch_needed, output ready);
endinterface

// ===== hw/rtl/weighted_lottery_task_picker_core.sv =====
// weighted lottery task picker: an input word passes the input register, then the result register;
// one word per cycle sustained while the result side is ready; scoring, xorshift32 step,
// 24x20 ticket multiply and prefix compare are combinational into the result register
// a word can sit in the result register while the next is taken in
// i_rst_n synchronous active low: task_count 1, active_mask 1, running slot 0,
// generator 0x98765432, both stages empty
`include "weighted_lottery_task_picker_core_assert.svh"

module weighted_lottery_task_picker_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wltp_pkg::ADDR_W-1:0]   paddr,
    input  logic [wltp_pkg::DATA_W-1:0]   pwdata,
    output logic [wltp_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    wltp_in_if.sink                       i_in,
    wltp_out_if.source                    o_out
);
    import wltp_pkg::*;

    // configuration registers
    t_count      r_task_count;
    t_mask       r_active_mask;
    t_reg_idx    reg_sel;
    logic        cfg_wr;

    // scheduler state
    t_slot       r_run, n_run;
    logic [31:0] r_prng, n_prng;

    // input stage
    logic        r_s1_vld;
    t_volt       r_v1, r_v3;

    // result stage
    logic        r_out_vld;
    t_slot       r_out_chosen, n_out_chosen;
    t_slot       r_out_prev;
    logic        r_out_switch, n_out_switch;

    logic        s1_adv;
    logic        in_acc;
    logic        tick_live;

    // ---------------------------------------------------------------
    // apb register port, writes only while idle: the user keeps to this, the block does not enforce it
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count  <= COUNT_RESET;
            r_active_mask <= MASK_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_TASK_COUNT:  r_task_count  <= pwdata[COUNT_W-1:0];
                REG_ACTIVE_MASK: r_active_mask <= pwdata[SLOT_COUNT-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_TASK_COUNT:  prdata[COUNT_W-1:0]    = r_task_count;
            REG_ACTIVE_MASK: prdata[SLOT_COUNT-1:0] = r_active_mask;
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // handshake: stage 1 moves on when the result register frees up
    // ---------------------------------------------------------------
    assign s1_adv     = r_s1_vld & (~r_out_vld | o_out.ready);
    assign i_in.ready = ~r_s1_vld | s1_adv;
    assign in_acc     = i_in.valid & i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_vld <= i_in.valid;
        end
    end

    // voltage payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_v1 <= i_in.voltage_slot1;
            r_v3 <= i_in.voltage_slot3;
        end
    end

    // ---------------------------------------------------------------
    // one tick: scores, generator step, ticket, first slot reaching it
    // ---------------------------------------------------------------
    always_comb begin
        t_count                    cnt;
        logic [SLOT_COUNT-1:0]     live;
        t_sum                      score [SLOT_COUNT];
        t_sum                      pre   [SLOT_COUNT];
        logic [31:0]               x1, x2, x3;
        logic signed [PROD_W-1:0]  prod;
        t_sum                      ticket;
        logic [SLOT_COUNT-1:0]     hit;

        // counts above the slot total clamp to it
        cnt = (r_task_count > t_count'(SLOT_COUNT)) ? t_count'(SLOT_COUNT) : r_task_count;
        tick_live = (cnt >= t_count'(2));

        for (int i = 0; i < SLOT_COUNT; i++) begin
            live[i] = (t_count'(i) < cnt) & r_active_mask[i];
        end

        // slot weights: 0.2, 0.1 + v1, 1.0, 0.1 + v3
        score[0] = live[0] ? SCORE_FIFTH : '0;
        score[1] = live[1] ? SCORE_TENTH + t_sum'(r_v1) : '0;
        score[2] = live[2] ? SCORE_ONE : '0;
        score[3] = live[3] ? SCORE_TENTH + t_sum'(r_v3) : '0;

        pre[0] = score[0];
        for (int i = 1; i < SLOT_COUNT; i++) begin
            pre[i] = pre[i-1] + score[i];
        end

        // xorshift32, shifts 13, 17, 5
        x1 = r_prng ^ (r_prng << 13);
        x2 = x1 ^ (x1 >> 17);
        x3 = x2 ^ (x2 << 5);

        // floor(frac24 * total / 2^24): arithmetic shift rounds toward minus infinity
        prod   = $signed({1'b0, x3[FRAC_W-1:0]}) * pre[SLOT_COUNT-1];
        ticket = prod[FRAC_W +: SUM_W];

        for (int i = 0; i < SLOT_COUNT; i++) begin
            hit[i] = live[i] & (pre[i] >= ticket);
        end

        // first hit wins, slot 0 when nothing reaches the ticket
        n_out_chosen = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (hit[i]) begin
                n_out_chosen = t_slot'(i);
            end
        end

        if (!tick_live) begin
            n_out_chosen = r_run;
        end
        n_out_switch = (n_out_chosen != r_run);

        n_run  = r_run;
        n_prng = r_prng;
        if (s1_adv && tick_live) begin
            n_run  = n_out_chosen;
            n_prng = x3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= '0;
            r_prng <= PRNG_RESET;
        end else begin
            r_run  <= n_run;
            r_prng <= n_prng;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_chosen <= n_out_chosen;
            r_out_prev   <= r_run;
            r_out_switch <= n_out_switch;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.chosen_slot   = r_out_chosen;
    assign o_out.previous_slot = r_out_prev;
    assign o_out.switch_needed = r_out_switch;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // xorshift never reaches zero from a nonzero seed
    `WLTP_ASSERT_NOW(a_prng_nonzero, 1'b1, r_prng != '0, "generator word reached zero")
    // the running slot follows every pick taken into the result register
    `WLTP_ASSERT_NEXT(a_run_follows, s1_adv, r_run == r_out_chosen,
        "running slot differs from the last pick")
    // generator only moves on a live tick
    `WLTP_ASSERT_NEXT(a_prng_hold, !(s1_adv && tick_live), $stable(r_prng),
        "generator advanced without a live tick")
    // an idle tick never reports a switch
    `WLTP_ASSERT_NEXT(a_idle_no_switch, s1_adv && !tick_live, !r_out_switch,
        "switch flagged on a tick with fewer than two tasks")

endmodule

// ===== sim/tb_weighted_lottery_task_picker_core.sv =====
// testbench for weighted_lottery_task_picker_core: scheduling tick words in, picks out,
// each pick checked against a cycle-free predictor of the lottery and the xorshift32 state
// depends on wltp_pkg, wltp_in_if, wltp_out_if and weighted_lottery_task_picker_core
module tb_weighted_lottery_task_picker_core;
    import wltp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned RAND_PHASES = 25;
    localparam int unsigned PHASE_TICKS = 50;

    // one expected pick
    typedef struct packed {
        t_slot chosen;
        t_slot prior;
        logic  swap;
    } pick_t;

    logic i_clk;
    logic i_rst_n;

    // apb-style register port
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    wltp_in_if  tick_bus ();
    wltp_out_if pick_bus ();

    weighted_lottery_task_picker_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (tick_bus.sink),
        .o_out   (pick_bus.source)
    );

    // scheduler state as the predictor sees it
    t_count      sched_count;
    t_mask       sched_mask;
    t_slot       sched_running;
    logic [31:0] sched_xs;

    pick_t       pending_picks[$];
    int unsigned err_count;
    int unsigned cycle_cnt;

    // idling knobs, percent chance per word or per cycle
    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;

    // clock, period 2
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // gap length: mostly short, one time in ten a long one
    function automatic int unsigned pick_gap();
        if ($urandom_range(9) == 0) begin
            return $urandom_range(32, 8);
        end
        return $urandom_range(3, 1);
    endfunction

    function automatic void note_error(string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("ERROR: %s", msg);
        end
    endfunction

    // lottery for one tick; with two or more slots counted, advances the running slot and the xorshift word
    function automatic pick_t predict_pick(t_volt v1, t_volt v3);
        int unsigned n;
        int          score[SLOT_COUNT];
        int          total;
        longint      frac;
        longint      ticket;
        longint      run_sum;
        logic [31:0] x;
        bit          found;
        pick_t       p;

        n       = (sched_count > SLOT_COUNT) ? SLOT_COUNT : sched_count;
        p.prior = sched_running;
        p.chosen = sched_running;
        if (n >= 2) begin
            total = 0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                score[i] = 0;
                // slots past the count or with a clear mask bit score nothing
                if (i < n && sched_mask[i]) begin
                    case (i)
                        0: score[i] = int'(SCORE_FIFTH);
                        1: score[i] = int'(SCORE_TENTH) + int'(v1);
                        2: score[i] = int'(SCORE_ONE);
                        default: score[i] = int'(SCORE_TENTH) + int'(v3);
                    endcase
                end
                total += score[i];
            end
            x = sched_xs;
            x ^= x << 13;
            x ^= x >> 17;
            x ^= x << 5;
            sched_xs = x;
            // floor of frac * total / 2^24, also for a negative total
            frac   = longint'(x[23:0]);
            ticket = (frac * longint'(total)) >>> 24;
            run_sum  = 0;
            found    = 1'b0;
            p.chosen = '0;
            for (int i = 0; i < n; i++) begin
                if (!found && sched_mask[i]) begin
                    run_sum += score[i];
                    if (run_sum >= ticket) begin
                        p.chosen = t_slot'(i);
                        found    = 1'b1;
                    end
                end
            end
            sched_running = p.chosen;
        end
        p.swap = (p.chosen != p.prior);
        return p;
    endfunction

    // one tick word: optional gap, then hold valid until the handshake
    task automatic send_tick(t_volt v1, t_volt v3);
        int unsigned gap;
        gap = (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            tick_bus.valid = 1'b0;
        end
        @(negedge i_clk);
        tick_bus.valid         = 1'b1;
        tick_bus.voltage_slot1 = v1;
        tick_bus.voltage_slot3 = v3;
        do begin
            @(posedge i_clk);
        end while (!tick_bus.ready);
        pending_picks.push_back(predict_pick(v1, v3));
    endtask

    // stop sending and wait for every pick still owed
    task automatic wait_idle();
        @(negedge i_clk);
        tick_bus.valid = 1'b0;
        while (pending_picks.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // setup cycle, then access cycle; written at the edge with pready high
    task automatic write_reg(t_reg_idx idx, logic [DATA_W-1:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        if (idx == REG_TASK_COUNT) begin
            sched_count = val[COUNT_W-1:0];
        end else begin
            sched_mask = val[SLOT_COUNT-1:0];
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // registers change only with the pipeline empty
    task automatic set_sched(int unsigned count, int unsigned mask);
        wait_idle();
        write_reg(REG_TASK_COUNT, DATA_W'(count));
        write_reg(REG_ACTIVE_MASK, DATA_W'(mask));
    endtask

    // voltages: full range, near the fixed scores, or edge values
    function automatic t_volt rand_volt();
        case ($urandom_range(3))
            0: return t_volt'($urandom());
            1: return t_volt'(int'($urandom_range(2048)) - 1024);
            2: return t_volt'(int'($urandom_range(8192)) - 4096);
            default: begin
                case ($urandom_range(5))
                    0: return t_volt'(-32768);
                    1: return t_volt'(32767);
                    2: return t_volt'(0);
                    3: return t_volt'(-410);
                    4: return t_volt'(-411);
                    default: return t_volt'(-409);
                endcase
            end
        endcase
    endfunction

    // after reset only one slot is in use, so nothing moves
    task automatic test_reset_defaults();
        send_tick(t_volt'(0), t_volt'(0));
        send_tick(t_volt'(-32768), t_volt'(32767));
        send_tick(t_volt'(32767), t_volt'(-32768));
    endtask

    // zero slots in use behaves like one
    task automatic test_count_zero();
        set_sched(0, 4'hF);
        send_tick(t_volt'(16'h7FFF), t_volt'(16'h8000));
    endtask

    // all four slots, voltage extremes and a negative total
    task automatic test_full_mask_extremes();
        set_sched(4, 4'hF);
        send_tick(t_volt'(32767), t_volt'(32767));
        send_tick(t_volt'(-32768), t_volt'(-32768));
        send_tick(t_volt'(0), t_volt'(0));
        send_tick(t_volt'(-410), t_volt'(-410));
        send_tick(t_volt'(16'h5555), t_volt'(16'hAAAA));
    endtask

    // counts above the slot count clamp to four
    task automatic test_oversized_count();
        set_sched(7, 4'hF);
        send_tick(t_volt'(1000), t_volt'(-2000));
        send_tick(t_volt'(16'hAAAA), t_volt'(16'h5555));
        set_sched(5, 4'hA);
        send_tick(t_volt'(4096), t_volt'(4096));
    endtask

    // mask bits past the count have no effect
    task automatic test_mask_beyond_count();
        set_sched(2, 4'hF);
        send_tick(t_volt'(8192), t_volt'(-32768));
        send_tick(t_volt'(-8192), t_volt'(32767));
    endtask

    // no active slot: zero total, fallback to slot 0
    task automatic test_empty_mask();
        set_sched(4, 4'h0);
        send_tick(t_volt'(32767), t_volt'(32767));
        send_tick(t_volt'(-32768), t_volt'(0));
    endtask

    // running slot dropped from the mask still shows as the previous slot
    task automatic test_inactive_running();
        set_sched(3, 4'h6);
        send_tick(t_volt'(2048), t_volt'(0));
        send_tick(t_volt'(-2048), t_volt'(0));
        set_sched(4, 4'h8);
        send_tick(t_volt'(0), t_volt'(20000));
        set_sched(4, 4'h1);
        send_tick(t_volt'(0), t_volt'(0));
    endtask

    // only the voltage slots active, with a negative total
    task automatic test_negative_total();
        set_sched(4, 4'hA);
        send_tick(t_volt'(-32768), t_volt'(-32768));
        send_tick(t_volt'(-20000), t_volt'(-1));
    endtask

    // random settings per phase, random voltages and pacing
    task automatic test_random_ticks();
        int unsigned count;
        int unsigned mask;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            // mostly enough slots for a lottery, sometimes a degenerate count
            count = ($urandom_range(4) == 0) ? $urandom_range(7) : $urandom_range(4, 2);
            mask  = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(15, 1);
            if (ph == 0) begin
                count = 4;
                mask  = 4'hF;
            end
            set_sched(count, mask);
            // every fifth phase runs flat out on both sides
            if (ph % 5 == 2) begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end else begin
                src_idle_pct  = $urandom_range(50, 5);
                snk_stall_pct = $urandom_range(50, 5);
            end
            repeat (PHASE_TICKS) begin
                send_tick(rand_volt(), rand_volt());
            end
        end
    endtask

    // sink pacing: ready drops for random stretches
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && snk_stall_pct != 0 && $urandom_range(99) < snk_stall_pct) begin
                stall_left = pick_gap();
            end
            if (stall_left != 0) begin
                pick_bus.ready = 1'b0;
                stall_left--;
            end else begin
                pick_bus.ready = 1'b1;
            end
        end
    end

    // result checker, oldest expectation first
    always @(posedge i_clk) begin
        pick_t exp_pick;
        if (i_rst_n && pick_bus.valid && pick_bus.ready) begin
            if (pending_picks.size() == 0) begin
                note_error($sformatf("unexpected pick: chosen %0d previous %0d switch %0b",
                    pick_bus.chosen_slot, pick_bus.previous_slot, pick_bus.switch_needed));
            end else begin
                exp_pick = pending_picks.pop_front();
                if (pick_bus.chosen_slot !== exp_pick.chosen
                        || pick_bus.previous_slot !== exp_pick.prior
                        || pick_bus.switch_needed !== exp_pick.swap) begin
                    note_error($sformatf(
                        "pick mismatch: expected chosen %0d previous %0d switch %0b, got %0d %0d %0b",
                        exp_pick.chosen, exp_pick.prior, exp_pick.swap,
                        pick_bus.chosen_slot, pick_bus.previous_slot, pick_bus.switch_needed));
                end
            end
        end
    end

    // run limit
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        // every input known from time zero
        i_rst_n                = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        tick_bus.valid         = 1'b0;
        tick_bus.voltage_slot1 = '0;
        tick_bus.voltage_slot3 = '0;
        pick_bus.ready         = 1'b0;
        err_count              = 0;
        src_idle_pct           = 20;
        snk_stall_pct          = 20;

        // predictor state after reset
        sched_count   = COUNT_RESET;
        sched_mask    = MASK_RESET;
        sched_running = '0;
        sched_xs      = PRNG_RESET;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_count_zero();
        test_full_mask_extremes();
        test_oversized_count();
        test_mask_beyond_count();
        test_empty_mask();
        test_inactive_running();
        test_negative_total();
        test_random_ticks();

        // drain, then keep clocking to catch stray picks
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== weighted_lottery_task_picker_core.f =====
+incdir+hw/rtl
hw/rtl/wltp_pkg.sv
hw/rtl/wltp_if.sv
hw/rtl/weighted_lottery_task_picker_core.sv
sim/tb_weighted_lottery_task_picker_core.sv
